FILE: hdl/bresenham_line_pixel_walker_unit_macros.svh
// ----------------------------------------------------------------------------
// Bresenham line pixel walker assertion macros
// Concurrent assertion wrappers that compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef BRESENHAM_LINE_PIXEL_WALKER_UNIT_MACROS_SVH
`define BRESENHAM_LINE_PIXEL_WALKER_UNIT_MACROS_SVH

`ifndef SYNTH
`define BLPW_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("assertion failed in bresenham line pixel walker");
`define BLPW_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("assertion failed in bresenham line pixel walker");
`else
`define BLPW_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define BLPW_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

FILE: hdl/blpw_pkg.sv
// ----------------------------------------------------------------------------
// Bresenham line pixel walker package
// Register indexes, operation codes, field widths and register reset values.
// ----------------------------------------------------------------------------
package blpw_pkg;

	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = 32;
	localparam int WIDTH_BITS     = 13;
	localparam int HEIGHT_BITS    = 13;
	localparam int STRIDE_BITS    = 16;
	localparam int PBYTES_BITS    = 4;
	localparam int ADDR_BITS      = 32;
	localparam int COLOR_BITS     = 32;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_SCREEN_WIDTH  = 3'd0,
		REG_SCREEN_HEIGHT = 3'd1,
		REG_ROW_STRIDE    = 3'd2,
		REG_PIXEL_BYTES   = 3'd3,
		REG_FRAME_BASE    = 3'd4
	} cfg_reg_t;

	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_STEP = 1'b1
	} op_t;

	localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = 13'd640;
	localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = 13'd480;
	localparam logic [STRIDE_BITS-1:0] STRIDE_RESET = 16'd2560;
	localparam logic [PBYTES_BITS-1:0] PBYTES_RESET = 4'd4;
	localparam logic [ADDR_BITS-1:0]   BASE_RESET   = 32'd0;

endpackage

FILE: hdl/blpw_ifs.sv
// ----------------------------------------------------------------------------
// Bresenham line pixel walker channel interfaces
// Command, pixel and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface blpw_cmd_if #(parameter int COORD_BITS = 16) ();
	import blpw_pkg::*;

	logic                         valid;
	logic                         ready;
	logic                         operation;
	logic signed [COORD_BITS-1:0] start_x;
	logic signed [COORD_BITS-1:0] start_y;
	logic signed [COORD_BITS-1:0] end_x;
	logic signed [COORD_BITS-1:0] end_y;
	logic signed [COORD_BITS-1:0] watch_x;
	logic signed [COORD_BITS-1:0] watch_y;
	logic [COLOR_BITS-1:0]        line_color;

	modport source (
		output valid, operation, start_x, start_y, end_x, end_y, watch_x, watch_y,
			line_color,
		input  ready
	);
	modport sink (
		input  valid, operation, start_x, start_y, end_x, end_y, watch_x, watch_y,
			line_color,
		output ready
	);
endinterface

interface blpw_pix_if #(parameter int COORD_BITS = 16) ();
	import blpw_pkg::*;

	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] pixel_x;
	logic signed [COORD_BITS-1:0] pixel_y;
	logic                         write_enable;
	logic [ADDR_BITS-1:0]         pixel_address;
	logic [COLOR_BITS-1:0]        pixel_color;
	logic                         hit_watch;
	logic                         line_end;

	modport source (
		output valid, pixel_x, pixel_y, write_enable, pixel_address, pixel_color,
			hit_watch, line_end,
		input  ready
	);
	modport sink (
		input  valid, pixel_x, pixel_y, write_enable, pixel_address, pixel_color,
			hit_watch, line_end,
		output ready
	);
endinterface

interface blpw_cfg_if ();
	import blpw_pkg::*;

	logic                      valid;
	logic                      ready;
	logic [CFG_INDEX_BITS-1:0] index;
	logic [CFG_DATA_BITS-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

FILE: hdl/bresenham_line_pixel_walker_unit.sv
// ----------------------------------------------------------------------------
// Bresenham line pixel walker
// Walks a loaded line one pixel per step command and emits frame-buffer writes.
// ----------------------------------------------------------------------------
// A load transaction on cmd records a line and produces no pixel; each step
// transaction then, while a line is active, advances the line by one Bresenham
// step and produces one pixel transaction on pix. The block accepts one command
// per clock unless pix stalls. A step's pixel passes through two registers: the
// step register holds the new coordinates and flags, and the address register
// behind it holds the frame-buffer address, formed by the row and column
// multipliers. cmd.ready follows pix.ready through the two registers, so a
// stalled pixel channel stops commands once both are full. Configuration
// writes are always taken and must be made while no line pixel is outstanding.
module bresenham_line_pixel_walker_unit #(
	parameter int COORD_BITS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	blpw_cmd_if.sink   cmd,
	blpw_cfg_if.sink   cfg,
	blpw_pix_if.source pix
);
	import blpw_pkg::*;

	`include "bresenham_line_pixel_walker_unit_macros.svh"

	localparam int SPAN_BITS = COORD_BITS + 2;
	localparam int ERR_BITS  = COORD_BITS + 3;
	localparam int E2_BITS   = ERR_BITS + 1;
	localparam int EXT_BITS  = ADDR_BITS - COORD_BITS;

	// Configuration registers
	logic [WIDTH_BITS-1:0]  width_q;
	logic [HEIGHT_BITS-1:0] height_q;
	logic [STRIDE_BITS-1:0] stride_q;
	logic [PBYTES_BITS-1:0] pbytes_q;
	logic [ADDR_BITS-1:0]   base_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
			stride_q <= STRIDE_RESET;
			pbytes_q <= PBYTES_RESET;
			base_q   <= BASE_RESET;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg_reg_t'(cfg.index))
				REG_SCREEN_WIDTH:  width_q  <= cfg.data[WIDTH_BITS-1:0];
				REG_SCREEN_HEIGHT: height_q <= cfg.data[HEIGHT_BITS-1:0];
				REG_ROW_STRIDE:    stride_q <= cfg.data[STRIDE_BITS-1:0];
				REG_PIXEL_BYTES:   pbytes_q <= cfg.data[PBYTES_BITS-1:0];
				REG_FRAME_BASE:    base_q   <= cfg.data[ADDR_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Line state
	logic signed [COORD_BITS-1:0] cur_x_q, cur_y_q, target_x_q, target_y_q;
	logic signed [COORD_BITS-1:0] watched_x_q, watched_y_q;
	logic signed [SPAN_BITS-1:0]  span_x_q, neg_span_y_q;
	logic signed [ERR_BITS-1:0]   err_q;
	logic                         step_left_q, step_up_q, line_active_q;
	logic [COLOR_BITS-1:0]        color_q;

	// Pipeline registers
	logic                         v_s1, v_s2;
	logic signed [COORD_BITS-1:0] x_s1, y_s1, x_s2, y_s2;
	logic                         hit_s1, end_s1, hit_s2, end_s2, on_s2;
	logic [COLOR_BITS-1:0]        color_s1, color_s2;
	logic [ADDR_BITS-1:0]         addr_s2;

	logic adv_s2, load_fire, step_emit;

	assign adv_s2    = !v_s2 || pix.ready;
	assign cmd.ready = !v_s1 || adv_s2;
	assign load_fire = cmd.valid && cmd.ready && (op_t'(cmd.operation) == OP_LOAD);
	assign step_emit = cmd.valid && cmd.ready && (op_t'(cmd.operation) == OP_STEP)
		&& line_active_q;

	// Load arithmetic
	logic signed [COORD_BITS:0]  dx, dy;
	logic signed [SPAN_BITS-1:0] dx_ext, dy_ext, span_x_c, neg_span_y_c;
	logic signed [ERR_BITS-1:0]  err_load_c;

	always_comb begin
		dx = {cmd.end_x[COORD_BITS-1], cmd.end_x} - {cmd.start_x[COORD_BITS-1], cmd.start_x};
		dy = {cmd.end_y[COORD_BITS-1], cmd.end_y} - {cmd.start_y[COORD_BITS-1], cmd.start_y};
		dx_ext = {dx[COORD_BITS], dx};
		dy_ext = {dy[COORD_BITS], dy};
		span_x_c     = dx[COORD_BITS] ? -dx_ext : dx_ext;
		neg_span_y_c = dy[COORD_BITS] ? dy_ext : -dy_ext;
		err_load_c   = ERR_BITS'(span_x_c) + ERR_BITS'(neg_span_y_c);
	end

	// One Bresenham step
	logic signed [E2_BITS-1:0]    e2;
	logic                         go_x, go_y;
	logic signed [ERR_BITS-1:0]   err_next;
	logic signed [COORD_BITS-1:0] nx, ny;
	logic                         hit_c, done_c;

	always_comb begin
		e2       = {err_q[ERR_BITS-1], err_q} <<< 1;
		go_x     = e2 >= E2_BITS'(neg_span_y_q);
		go_y     = e2 <= E2_BITS'(span_x_q);
		err_next = err_q;
		nx       = cur_x_q;
		ny       = cur_y_q;
		if (go_x) begin
			err_next = err_next + ERR_BITS'(neg_span_y_q);
			nx       = step_left_q ? cur_x_q - 1'b1 : cur_x_q + 1'b1;
		end
		if (go_y) begin
			err_next = err_next + ERR_BITS'(span_x_q);
			ny       = step_up_q ? cur_y_q - 1'b1 : cur_y_q + 1'b1;
		end
		hit_c  = (nx == watched_x_q) && (ny == watched_y_q);
		done_c = hit_c || ((nx == target_x_q) && (ny == target_y_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q       <= '0;
			cur_y_q       <= '0;
			target_x_q    <= '0;
			target_y_q    <= '0;
			watched_x_q   <= '0;
			watched_y_q   <= '0;
			span_x_q      <= '0;
			neg_span_y_q  <= '0;
			err_q         <= '0;
			step_left_q   <= 1'b0;
			step_up_q     <= 1'b0;
			color_q       <= '0;
			line_active_q <= 1'b0;
		end else if (load_fire) begin
			cur_x_q       <= cmd.start_x;
			cur_y_q       <= cmd.start_y;
			target_x_q    <= cmd.end_x;
			target_y_q    <= cmd.end_y;
			watched_x_q   <= cmd.watch_x;
			watched_y_q   <= cmd.watch_y;
			span_x_q      <= span_x_c;
			neg_span_y_q  <= neg_span_y_c;
			err_q         <= err_load_c;
			step_left_q   <= !(cmd.start_x < cmd.end_x);
			step_up_q     <= !(cmd.start_y < cmd.end_y);
			color_q       <= cmd.line_color;
			line_active_q <= !((cmd.start_x == cmd.end_x) && (cmd.start_y == cmd.end_y));
		end else if (step_emit) begin
			cur_x_q       <= nx;
			cur_y_q       <= ny;
			err_q         <= err_next;
			line_active_q <= !done_c;
		end
	end

	// Step register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (cmd.ready) begin
			v_s1 <= step_emit;
		end
	end

	always_ff @(posedge clk) begin
		if (step_emit) begin
			x_s1     <= nx;
			y_s1     <= ny;
			hit_s1   <= hit_c;
			end_s1   <= done_c;
			color_s1 <= color_q;
		end
	end

	// Address register
	logic [ADDR_BITS-1:0] x_ext, y_ext, x_term, y_term;
	logic                 on_c;

	always_comb begin
		x_ext  = {{EXT_BITS{x_s1[COORD_BITS-1]}}, x_s1};
		y_ext  = {{EXT_BITS{y_s1[COORD_BITS-1]}}, y_s1};
		y_term = y_ext * ADDR_BITS'(stride_q);
		x_term = x_ext * ADDR_BITS'(pbytes_q);
		on_c   = !x_s1[COORD_BITS-1] && !y_s1[COORD_BITS-1]
			&& (x_ext < ADDR_BITS'(width_q)) && (y_ext < ADDR_BITS'(height_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && v_s1) begin
			x_s2     <= x_s1;
			y_s2     <= y_s1;
			on_s2    <= on_c;
			addr_s2  <= base_q + y_term + x_term;
			color_s2 <= color_s1;
			hit_s2   <= hit_s1;
			end_s2   <= end_s1;
		end
	end

	assign pix.valid         = v_s2;
	assign pix.pixel_x       = x_s2;
	assign pix.pixel_y       = y_s2;
	assign pix.write_enable  = on_s2;
	assign pix.pixel_address = addr_s2;
	assign pix.pixel_color   = color_s2;
	assign pix.hit_watch     = hit_s2;
	assign pix.line_end      = end_s2;

	`BLPW_ASSERT_IMP(a_hit_ends_line, clk, arst_n, pix.valid && pix.hit_watch, pix.line_end)
	`BLPW_ASSERT_IMP(a_write_on_screen, clk, arst_n, pix.valid && pix.write_enable,
		!pix.pixel_x[COORD_BITS-1] && !pix.pixel_y[COORD_BITS-1])
	`BLPW_ASSERT_NXT(a_done_stops_line, clk, arst_n, step_emit && done_c, !line_active_q)
	`BLPW_ASSERT_NXT(a_point_line_idle, clk, arst_n,
		load_fire && (cmd.start_x == cmd.end_x) && (cmd.start_y == cmd.end_y),
		!line_active_q)

endmodule
